// ===== rtl/sida_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; used by every module of the unit.
`default_nettype none

package sida_pkg;

   // input value and decimal digit geometry
   localparam int VALUE_W       = 64;
   localparam int NUM_DIGITS    = 20;
   localparam int DIGIT_W       = 4;
   localparam int DIGIT_IDX_W   = 5;
   localparam int CHAR_W        = 6;

   // binary to BCD conversion: bits consumed per step and number of steps
   localparam int BITS_PER_STEP = 4;
   localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(NUM_STEPS);

   // character codes, already reduced to six bits
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

   // one converted number as it travels from the front to the back
   typedef struct packed {
      logic                                  neg;
      logic [DIGIT_IDX_W-1:0]                top_idx;
      logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    digits;
   } job_type;

endpackage

`default_nettype wire

// ===== rtl/sida_front.sv =====
// Front part: takes a value, forms its sign and magnitude and converts the
// magnitude to BCD, four bits a cycle. Depends on sida_pkg.
`default_nettype none

module sida_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [sida_pkg::VALUE_W-1:0] req_value,
   output logic                               job_push,
   input  wire logic                          job_full,
   output sida_pkg::job_type                  job_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PUSH
   } state_type;

   state_type                                                   state_ff, state_in;
   logic [sida_pkg::STEP_W-1:0]                                 step_ff, step_in;
   logic                                                        neg_ff, neg_in;
   logic [sida_pkg::VALUE_W-1:0]                                bin_ff, bin_in;
   logic [sida_pkg::NUM_DIGITS-1:0][sida_pkg::DIGIT_W-1:0]      bcd_ff, bcd_in;

   logic [sida_pkg::VALUE_W-1:0]                                mag;
   logic [sida_pkg::NUM_DIGITS-1:0][sida_pkg::DIGIT_W-1:0]      bcd_work;
   logic [sida_pkg::VALUE_W-1:0]                                bin_work;
   logic [sida_pkg::DIGIT_IDX_W-1:0]                            top_idx;

   localparam logic [sida_pkg::STEP_W-1:0] LAST_STEP = sida_pkg::STEP_W'(sida_pkg::NUM_STEPS - 1);

   // magnitude as unsigned, so the most negative value maps to 2^63
   assign mag = req_value[sida_pkg::VALUE_W-1]
                ? (~req_value) + sida_pkg::VALUE_W'(1)
                : req_value;

   // double dabble: adjust every digit, then shift one bit in, per bit
   always_comb begin
      bcd_work = bcd_ff;
      bin_work = bin_ff;
      for (int b = 0; b < sida_pkg::BITS_PER_STEP; b++) begin
         for (int d = 0; d < sida_pkg::NUM_DIGITS; d++) begin
            if (bcd_work[d] >= sida_pkg::DIGIT_W'(5)) begin
               bcd_work[d] = bcd_work[d] + sida_pkg::DIGIT_W'(3);
            end
         end
         {bcd_work, bin_work} = {bcd_work, bin_work} << 1;
      end
   end

   // highest non-zero digit; zero keeps index 0 and prints '0'
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < sida_pkg::NUM_DIGITS; d++) begin
         if (bcd_ff[d] != '0) begin
            top_idx = sida_pkg::DIGIT_IDX_W'(d);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_push) begin
               neg_in   = req_value[sida_pkg::VALUE_W-1];
               bin_in   = mag;
               bcd_in   = '0;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bin_in  = bin_work;
            bcd_in  = bcd_work;
            step_in = step_ff + sida_pkg::STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!job_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      neg_ff <= neg_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign req_full         = (state_ff != ST_IDLE);
   assign job_push         = (state_ff == ST_PUSH);
   assign job_data.neg     = neg_ff;
   assign job_data.top_idx = top_idx;
   assign job_data.digits  = bcd_ff;

endmodule

`default_nettype wire

// ===== rtl/sida_queue.sv =====
// Short queue of converted numbers between the front and back parts.
// Depends on sida_pkg for the entry type.
`default_nettype none

module sida_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  sida_pkg::job_type data_in,
   output logic              empty,
   input  wire logic         pop,
   output sida_pkg::job_type data_out
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   sida_pkg::job_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = entries_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sida_back.sv =====
// Back part: walks one converted number and hands out its characters,
// sign first, one beat per character. Depends on sida_pkg.
`default_nettype none

module sida_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   input  sida_pkg::job_type                  job_data,
   output logic                               job_pop,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [sida_pkg::CHAR_W-1:0]        rsp_ascii_char,
   output logic                               rsp_last
);

   logic                                                    busy_ff, busy_in;
   logic                                                    sign_ff, sign_in;
   logic [sida_pkg::DIGIT_IDX_W-1:0]                        idx_ff, idx_in;
   logic [sida_pkg::NUM_DIGITS-1:0][sida_pkg::DIGIT_W-1:0]  digits_ff, digits_in;

   logic [sida_pkg::DIGIT_W-1:0]                            cur_digit;
   logic                                                    beat;

   // current character
   assign cur_digit      = digits_ff[idx_ff];
   assign rsp_empty      = !busy_ff;
   assign rsp_ascii_char = sign_ff ? sida_pkg::CH_MINUS
                         : sida_pkg::CH_ZERO + sida_pkg::CHAR_W'(cur_digit);
   assign rsp_last       = !sign_ff && (idx_ff == '0);
   assign beat           = busy_ff && rsp_pop;

   // next number may load in the cycle the final beat of this one leaves
   assign job_pop = job_valid && (!busy_ff || (beat && rsp_last));

   always_comb begin
      busy_in   = busy_ff;
      sign_in   = sign_ff;
      idx_in    = idx_ff;
      digits_in = digits_ff;
      if (job_pop) begin
         busy_in   = 1'b1;
         sign_in   = job_data.neg;
         idx_in    = job_data.top_idx;
         digits_in = job_data.digits;
      end else if (beat) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (idx_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - sida_pkg::DIGIT_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sign_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         sign_ff <= sign_in;
         idx_ff  <= idx_in;
      end
      digits_ff <= digits_in;
   end

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// The front takes no new value until the last one has gone through the
// four-bit-per-cycle BCD converter and into the queue; the back sends one
// character a cycle while rsp_pop is high, at most 20 per number.
// Reset clears the sequencer, the queue pointers and the output stage; a
// number in flight is dropped. Depends on sida_pkg, sida_front/queue/back.
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic signed [sida_pkg::VALUE_W-1:0]  req_value,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic [sida_pkg::CHAR_W-1:0]               rsp_ascii_char,
   output logic                                      rsp_last
);

   logic              q_push, q_full, q_empty, q_pop;
   sida_pkg::job_type q_wr_data, q_rd_data;

   // sign, magnitude and BCD conversion
   sida_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .job_push  (q_push),
      .job_full  (q_full),
      .job_data  (q_wr_data)
   );

   // decoupling queue
   sida_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .full     (q_full),
      .data_in  (q_wr_data),
      .empty    (q_empty),
      .pop      (q_pop),
      .data_out (q_rd_data)
   );

   // character output
   sida_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (!q_empty),
      .job_data       (q_rd_data),
      .job_pop        (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   // a beat on offer is a minus sign or a decimal digit
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_ascii_char == sida_pkg::CH_MINUS) ||
                     ((rsp_ascii_char >= sida_pkg::CH_ZERO) &&
                      (rsp_ascii_char <= sida_pkg::CH_ZERO + 6'd9)))
      else $error("character out of range");

   // the minus sign never closes a number
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_ascii_char == sida_pkg::CH_MINUS)) |-> !rsp_last)
      else $error("minus sign marked last");

   // taking a beat that is not last leaves more of the same number
   a_number_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last) |=> !rsp_empty)
      else $error("number cut short");

   // the back only loads from a non-empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue underflow");

endmodule

`default_nettype wire
